/* sv/rmce_pkg.sv */
// Shared constants and types for the resistor marking code encoder.
// Used by rmce_bin2bcd, rmce_code_gen and resistor_marking_code_encoder_top.
// No dependencies.
package rmce_pkg;

    // Input range
    localparam int RES_W = 50;
    localparam logic [RES_W-1:0] RES_HIGH = 50'd999499999999999;

    // Decimal conversion: 15 digits cover every saturated input
    localparam int NUM_DIGITS     = 15;
    localparam int DIGIT_W        = 4;
    localparam int BITS_PER_STAGE = 8;
    localparam int BCD_STAGES     = 7;
    localparam int PAD_W          = BCD_STAGES * BITS_PER_STAGE;

    // Exponent limits of the band codes
    localparam logic [3:0] MAX_BAND_EXP = 4'd9;
    // Decade offsets: exponent starts at digit count minus these
    localparam logic [3:0] FOUR_BAND_OFS = 4'd5;
    localparam logic [3:0] FIVE_BAND_OFS = 4'd6;
    // Digit position of one ohm (milliohm input)
    localparam logic [3:0] OHM_POS = 4'd3;

    // Input register, BCD stages, decade, window, normalize stages
    localparam int PIPE_LATENCY = BCD_STAGES + 4;

    typedef logic [DIGIT_W-1:0] bcd_digit_t;
    typedef bcd_digit_t [NUM_DIGITS-1:0] bcd_word_t;
    typedef bcd_digit_t [3:0] bcd4_t;

    // Transaction leaving the decimal conversion pipeline
    typedef struct packed {
        logic      valid;
        bcd_word_t digits;
    } bcd_item_t;

    // Finished result transaction
    typedef struct packed {
        logic       valid;
        logic       code_valid;
        logic [3:0] four_band_first;
        logic [3:0] four_band_second;
        logic [3:0] four_band_mult;
        logic [3:0] five_band_first;
        logic [3:0] five_band_second;
        logic [3:0] five_band_third;
        logic [3:0] five_band_mult;
        logic       smd_r_form;
        logic [6:0] smd_lead;
        logic [3:0] smd_tail;
    } code_t;

endpackage

/* sv/rmce_bin2bcd.sv */
// Pipelined binary to BCD converter (shift and add-3), eight bits per stage.
// Depends on rmce_pkg.
module rmce_bin2bcd
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [rmce_pkg::RES_W-1:0]   in_value,
    output rmce_pkg::bcd_item_t          out
);

    logic [rmce_pkg::BCD_STAGES-1:0] vld_reg;
    logic [rmce_pkg::PAD_W-1:0]      bin_reg  [rmce_pkg::BCD_STAGES];
    logic [rmce_pkg::PAD_W-1:0]      bin_next [rmce_pkg::BCD_STAGES];
    rmce_pkg::bcd_word_t             bcd_reg  [rmce_pkg::BCD_STAGES];
    rmce_pkg::bcd_word_t             bcd_next [rmce_pkg::BCD_STAGES];

    // One shift-and-add-3 step: adjust every digit, then shift in one bit
    function automatic rmce_pkg::bcd_word_t dabble(input rmce_pkg::bcd_word_t b,
                                                   input logic bit_in);
        rmce_pkg::bcd_word_t                          t;
        logic [rmce_pkg::DIGIT_W*rmce_pkg::NUM_DIGITS:0] wide;
        t = b;
        for (int i = 0; i < rmce_pkg::NUM_DIGITS; i++)
        begin
            if (t[i] >= 4'd5)
            begin
                t[i] = t[i] + 4'd3;
            end
        end
        wide = {t, bit_in};
        return wide[rmce_pkg::DIGIT_W*rmce_pkg::NUM_DIGITS-1:0];
    endfunction

    for (genvar s = 0; s < rmce_pkg::BCD_STAGES; s++)
    begin : g_stage
        logic [rmce_pkg::PAD_W-1:0] bin_cur;
        rmce_pkg::bcd_word_t        bcd_cur;
        logic                       vld_cur;
        rmce_pkg::bcd_word_t        acc;

        if (s == 0)
        begin : g_first
            assign bin_cur = rmce_pkg::PAD_W'(in_value);
            assign bcd_cur = '0;
            assign vld_cur = in_valid;
        end
        else
        begin : g_rest
            assign bin_cur = bin_reg[s-1];
            assign bcd_cur = bcd_reg[s-1];
            assign vld_cur = vld_reg[s-1];
        end

        // Consume the top bits of the remaining binary word
        always_comb
        begin
            acc = bcd_cur;
            for (int i = 0; i < rmce_pkg::BITS_PER_STAGE; i++)
            begin
                acc = dabble(acc, bin_cur[rmce_pkg::PAD_W-1-i]);
            end
            bcd_next[s] = acc;
            bin_next[s] = bin_cur << rmce_pkg::BITS_PER_STAGE;
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_cur;
            end
        end

        // Advance the payload
        always_ff @(posedge clk)
        begin
            bin_reg[s] <= bin_next[s];
            bcd_reg[s] <= bcd_next[s];
        end
    end

    assign out.valid  = vld_reg[rmce_pkg::BCD_STAGES-1];
    assign out.digits = bcd_reg[rmce_pkg::BCD_STAGES-1];

endmodule

/* sv/rmce_code_gen.sv */
// Decade detection, rounding and renormalization of the marking codes.
// Three register stages on decimal digits. Depends on rmce_pkg.
module rmce_code_gen
(
    input  logic                clk,
    input  logic                rst_n,
    input  rmce_pkg::bcd_item_t in,
    output rmce_pkg::code_t     out
);

    typedef struct packed {
        rmce_pkg::bcd4_t sig;
        logic [3:0]      exp;
    } norm_t;

    // Decade stage
    logic                digit_cnt;
    logic [3:0]          dcount;
    logic [3:0]          a_e4_next;
    logic [3:0]          a_e5_next;
    logic                a_vld_reg;
    rmce_pkg::bcd_word_t a_digits_reg;
    logic [3:0]          a_e4_reg;
    logic [3:0]          a_e5_reg;
    logic                a_nz_reg;

    // Window stage
    logic [3:0]          k4;
    logic [3:0]          k5;
    rmce_pkg::bcd4_t     b_c4_next;
    rmce_pkg::bcd4_t     b_c5_next;
    logic [3:0]          b_tenths_next;
    logic                b_vld_reg;
    rmce_pkg::bcd4_t     b_c4_reg;
    rmce_pkg::bcd4_t     b_c5_reg;
    logic [3:0]          b_e4_reg;
    logic [3:0]          b_e5_reg;
    logic                b_rform_reg;
    logic [3:0]          b_lead_reg;
    logic [3:0]          b_tenths_reg;
    logic                b_nz_reg;

    // Normalize stage
    norm_t               n4;
    norm_t               n5;
    logic [9:0]          lead_bin;
    rmce_pkg::code_t     code_next;
    logic                code_vld_reg;
    rmce_pkg::code_t     code_reg;

    // Round a three-digit window up by one, carrying into a fourth digit
    function automatic rmce_pkg::bcd4_t bcd_round(input rmce_pkg::bcd_digit_t d2,
                                                  input rmce_pkg::bcd_digit_t d1,
                                                  input rmce_pkg::bcd_digit_t d0,
                                                  input logic up);
        rmce_pkg::bcd4_t c;
        logic            carry;
        c     = {4'd0, d2, d1, d0};
        carry = up;
        for (int i = 0; i < 4; i++)
        begin
            if (carry)
            begin
                if (c[i] == 4'd9)
                begin
                    c[i] = 4'd0;
                end
                else
                begin
                    c[i]  = c[i] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return c;
    endfunction

    // Drop a digit when too long, append a zero when too short
    function automatic norm_t renorm(input rmce_pkg::bcd4_t c, input logic [3:0] e,
                                     input logic three_digits);
        norm_t r;
        logic  big;
        logic  short;
        r.sig = c;
        r.exp = e;
        big   = (c[3] != 4'd0) || (!three_digits && (c[2] != 4'd0));
        if (big)
        begin
            r.sig = {4'd0, c[3], c[2], c[1]};
            r.exp = e + 4'd1;
        end
        short = (r.sig[3] == 4'd0) && (r.sig[2] == 4'd0)
                && (three_digits || (r.sig[1] == 4'd0));
        if (short)
        begin
            r.sig = {r.sig[2], r.sig[1], r.sig[0], 4'd0};
            if (r.exp != 4'd0)
            begin
                r.exp = r.exp - 4'd1;
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] band_clamp(input logic [3:0] e);
        return (e > rmce_pkg::MAX_BAND_EXP) ? rmce_pkg::MAX_BAND_EXP : e;
    endfunction

    // Count significant digits and derive the starting exponents
    assign digit_cnt = (dcount != 4'd0);

    always_comb
    begin
        dcount = 4'd0;
        for (int i = 0; i < rmce_pkg::NUM_DIGITS; i++)
        begin
            if (in.digits[i] != 4'd0)
            begin
                dcount = 4'(i + 1);
            end
        end
        a_e4_next = 4'd0;
        if (dcount > rmce_pkg::FOUR_BAND_OFS)
        begin
            a_e4_next = band_clamp(dcount - rmce_pkg::FOUR_BAND_OFS);
        end
        a_e5_next = 4'd0;
        if (dcount > rmce_pkg::FIVE_BAND_OFS)
        begin
            a_e5_next = band_clamp(dcount - rmce_pkg::FIVE_BAND_OFS);
        end
    end

    // Select the digit windows and round half up
    assign k4 = a_e4_reg + rmce_pkg::OHM_POS;
    assign k5 = a_e5_reg + rmce_pkg::OHM_POS;

    always_comb
    begin
        b_c4_next = bcd_round(a_digits_reg[k4 + 4'd2], a_digits_reg[k4 + 4'd1],
                              a_digits_reg[k4], a_digits_reg[k4 - 4'd1] >= 4'd5);
        b_c5_next = bcd_round(a_digits_reg[k5 + 4'd2], a_digits_reg[k5 + 4'd1],
                              a_digits_reg[k5], a_digits_reg[k5 - 4'd1] >= 4'd5);
        // Tenths of R notation wrap to zero on a carry
        b_tenths_next = a_digits_reg[2] + {3'd0, a_digits_reg[1] >= 4'd5};
        if (b_tenths_next == 4'd10)
        begin
            b_tenths_next = 4'd0;
        end
    end

    // Renormalize and assemble the result
    assign n4       = renorm(b_c4_reg, b_e4_reg, 1'b0);
    assign n5       = renorm(b_c5_reg, b_e5_reg, 1'b1);
    assign lead_bin = 10'(n4.sig[2]) * 10'd100 + 10'(n4.sig[1]) * 10'd10
                      + 10'(n4.sig[0]);

    always_comb
    begin
        code_next = '0;
        code_next.valid = b_vld_reg;
        if (b_nz_reg)
        begin
            code_next.code_valid       = 1'b1;
            code_next.four_band_first  = n4.sig[1];
            code_next.four_band_second = n4.sig[0];
            code_next.four_band_mult   = band_clamp(n4.exp);
            code_next.five_band_first  = n5.sig[2];
            code_next.five_band_second = n5.sig[1];
            code_next.five_band_third  = n5.sig[0];
            code_next.five_band_mult   = band_clamp(n5.exp);
            code_next.smd_r_form       = b_rform_reg;
            if (b_rform_reg)
            begin
                code_next.smd_lead = {3'd0, b_lead_reg};
                code_next.smd_tail = b_tenths_reg;
            end
            else
            begin
                code_next.smd_lead = lead_bin[6:0];
                code_next.smd_tail = n4.exp;
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            code_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg    <= in.valid;
            b_vld_reg    <= a_vld_reg;
            code_vld_reg <= b_vld_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        a_digits_reg <= in.digits;
        a_e4_reg     <= a_e4_next;
        a_e5_reg     <= a_e5_next;
        a_nz_reg     <= digit_cnt;

        b_c4_reg     <= b_c4_next;
        b_c5_reg     <= b_c5_next;
        b_e4_reg     <= a_e4_reg;
        b_e5_reg     <= a_e5_reg;
        b_rform_reg  <= (a_digits_reg[rmce_pkg::NUM_DIGITS-1:4] == '0);
        b_lead_reg   <= a_digits_reg[3];
        b_tenths_reg <= b_tenths_next;
        b_nz_reg     <= a_nz_reg;

        code_reg     <= code_next;
    end

    always_comb
    begin
        out       = code_reg;
        out.valid = code_vld_reg;
    end

endmodule

/* sv/resistor_marking_code_encoder_top.sv */
// Top level of the resistor marking code encoder.
// Depends on rmce_pkg, rmce_bin2bcd and rmce_code_gen.
//
// Usage:
//   Drive resistance_milliohm and raise start; the transaction is accepted at
//   a rising edge where start is high and busy is low. busy is high only while
//   the block comes out of reset, so one transaction can be taken every cycle.
//   Each result is shown on the result ports for one cycle with done high and
//   is taken at the edge that ends that cycle; the receiver cannot stall, so
//   results are never held back.
// Pipeline and throughput:
//   The result of an accepted transaction passes through the input register,
//   seven binary-to-decimal stages of eight bits each, and three stages for
//   decade, rounding and renormalization. One transaction per cycle is
//   sustained.
// Reset:
//   rst_n clears all valid bits; transactions in flight are dropped.
// Inputs above the supported range saturate; a zero input returns
//   code_valid low with all fields zero.
module resistor_marking_code_encoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [49:0] resistance_milliohm,
    output logic        done,
    output logic        code_valid,
    output logic [3:0]  four_band_first,
    output logic [3:0]  four_band_second,
    output logic [3:0]  four_band_mult,
    output logic [3:0]  five_band_first,
    output logic [3:0]  five_band_second,
    output logic [3:0]  five_band_third,
    output logic [3:0]  five_band_mult,
    output logic        smd_r_form,
    output logic [6:0]  smd_lead,
    output logic [3:0]  smd_tail
);

    logic                         busy_reg;
    logic                         busy_next;
    logic                         accept;
    logic                         in_vld_reg;
    logic [rmce_pkg::RES_W-1:0]   in_m_reg;
    logic [rmce_pkg::RES_W-1:0]   m_sat;
    rmce_pkg::bcd_item_t          bcd_item;
    rmce_pkg::code_t              code;

    // Hold busy through reset release only
    assign busy_next = 1'b0;
    assign accept    = start && !busy_reg;

    // Saturate at the upper bound
    assign m_sat = (resistance_milliohm > rmce_pkg::RES_HIGH) ? rmce_pkg::RES_HIGH
                                                              : resistance_milliohm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b1;
            in_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            in_vld_reg <= accept;
        end
    end

    // Capture the input transaction
    always_ff @(posedge clk)
    begin
        in_m_reg <= m_sat;
    end

    rmce_bin2bcd u_bin2bcd
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_vld_reg),
        .in_value (in_m_reg),
        .out      (bcd_item)
    );

    rmce_code_gen u_code_gen
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (bcd_item),
        .out   (code)
    );

    // Drive the result ports from the output register
    assign busy             = busy_reg;
    assign done             = code.valid;
    assign code_valid       = code.code_valid;
    assign four_band_first  = code.four_band_first;
    assign four_band_second = code.four_band_second;
    assign four_band_mult   = code.four_band_mult;
    assign five_band_first  = code.five_band_first;
    assign five_band_second = code.five_band_second;
    assign five_band_third  = code.five_band_third;
    assign five_band_mult   = code.five_band_mult;
    assign smd_r_form       = code.smd_r_form;
    assign smd_lead         = code.smd_lead;
    assign smd_tail         = code.smd_tail;

    // Every accepted transaction comes out after the pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(rmce_pkg::PIPE_LATENCY) done)
        else $error("result missing after pipeline latency");

    // An invalid code carries all-zero fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !code_valid) |-> (four_band_first == 4'd0 && four_band_mult == 4'd0
            && five_band_first == 4'd0 && five_band_mult == 4'd0
            && !smd_r_form && smd_lead == 7'd0 && smd_tail == 4'd0))
        else $error("invalid code with nonzero fields");

    // Band digits and multipliers stay decimal
    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (four_band_first <= 4'd9 && four_band_second <= 4'd9
            && four_band_mult <= 4'd9 && five_band_first <= 4'd9
            && five_band_second <= 4'd9 && five_band_third <= 4'd9
            && five_band_mult <= 4'd9))
        else $error("band field out of decimal range");

    // SMD digit form always has two significant digits
    a_smd_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (done && code_valid && !smd_r_form) |->
            (smd_lead >= 7'd10 && smd_lead <= 7'd99 && smd_tail <= 4'd10))
        else $error("SMD digit form out of range");

    // SMD R notation holds whole ohms and tenths below ten
    a_smd_rform: assert property (@(posedge clk) disable iff (!rst_n)
        (done && smd_r_form) |-> (code_valid && smd_lead <= 7'd9 && smd_tail <= 4'd9))
        else $error("SMD R notation out of range");

endmodule
